// ===== rtl/core/lj_pkg.sv =====
// shared types, constants and fixed-point helpers for the lennard-jones force engine
// no dependencies; used by lj_mul, lj_div and the top level
package lj_pkg;

   localparam int unsigned POS_W   = 32;
   localparam int unsigned ACC_W   = 48;
   localparam int unsigned MAG_W   = 47;
   localparam int unsigned PROD_W  = 96;
   localparam int unsigned HALF_W  = 24;
   localparam int unsigned OPD_W   = 48;
   localparam int unsigned QUO_W   = 57;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned REQ_W   = 96;
   localparam int unsigned RSP_W   = 200;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SIZE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_ENABLE = 2'd2;

   localparam logic [POS_W-1:0] BOX_RESET    = 32'h000A_0000;
   localparam logic [POS_W-1:0] CUTOFF_RESET = 32'h0002_8000;

   // largest unsigned Q24.24 magnitude
   localparam logic [MAG_W-1:0] CAP = 47'h7FFF_FFFF_FFFF;
   localparam logic signed [53:0] SMAX54 = 54'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [53:0] SMIN54 = -54'sh0_7FFF_FFFF_FFFF - 54'sh1;

   // micro-steps that share the multiplier
   typedef enum logic [4:0] {
      MS_CUT, MS_SQX, MS_SQY, MS_SQZ, MS_U2, MS_U3, MS_U4, MS_U6, MS_U7,
      MS_TX, MS_TY, MS_TZ, MS_WD2, MS_W2, MS_W4, MS_W5,
      MS_Q2, MS_Q4, MS_Q8, MS_Q9
   } step_type;

   typedef struct packed {
      logic             start;
      logic [OPD_W-1:0] a;
      logic [OPD_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic        small_num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quo;
   } div_rsp_type;

   // product shifted down by 24, capped
   function automatic logic [MAG_W-1:0] sat_shr24(input logic [PROD_W-1:0] p);
      logic [71:0] v;
      v = p[95:24];
      return (v > 72'(CAP)) ? CAP : v[46:0];
   endfunction

   // product shifted down by 16, capped
   function automatic logic [MAG_W-1:0] sat_shr16(input logic [PROD_W-1:0] p);
      logic [79:0] v;
      v = p[95:16];
      return (v > 80'(CAP)) ? CAP : v[46:0];
   endfunction

   // saturating add into signed Q24.24
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [52:0] t);
      logic signed [53:0] s;
      s = {{6{acc[47]}}, acc} + {t[52], t};
      if (s > SMAX54) begin
         s = SMAX54;
      end else if (s < SMIN54) begin
         s = SMIN54;
      end
      return s[47:0];
   endfunction

   // saturating 64-bit unsigned add
   function automatic logic [63:0] sat_add64(input logic [63:0] s, input logic [63:0] q);
      logic [64:0] t;
      t = {1'b0, s} + {1'b0, q};
      return t[64] ? '1 : t[63:0];
   endfunction

   function automatic logic [31:0] abs33(input logic [32:0] d);
      logic [32:0] n;
      n = d[32] ? -d : d;
      return n[31:0];
   endfunction

   function automatic logic [31:0] abs34(input logic [33:0] d);
      logic [33:0] n;
      n = d[33] ? -d : d;
      return n[31:0];
   endfunction

   function automatic logic [52:0] sx53(input logic [ACC_W-1:0] t);
      return {{5{t[47]}}, t};
   endfunction

endpackage

// ===== rtl/core/lj_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lj_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lj_mul.sv =====
// shared 48x48 multiplier, one 24x24 partial product per cycle
// depends on lj_pkg
module lj_mul (
   input  logic                clock,
   input  logic                reset,
   input  lj_pkg::mul_req_type req,
   output lj_pkg::mul_rsp_type rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [1:0]                      cnt_ff, cnt_in;
   logic [lj_pkg::OPD_W-1:0]        a_ff, a_in, b_ff, b_in;
   logic [lj_pkg::PROD_W-1:0]       acc_ff, acc_in;
   logic [lj_pkg::HALF_W-1:0]       pa, pb;
   logic [lj_pkg::OPD_W-1:0]        pp;
   logic [lj_pkg::PROD_W-1:0]       pp_sh;

   // partial product selection
   assign pa = cnt_ff[0] ? a_ff[47:24] : a_ff[23:0];
   assign pb = cnt_ff[1] ? b_ff[47:24] : b_ff[23:0];
   assign pp = {24'b0, pa} * {24'b0, pb};

   always_comb begin
      case (cnt_ff)
         2'b00:   pp_sh = {48'b0, pp};
         2'b01:   pp_sh = {24'b0, pp, 24'b0};
         2'b10:   pp_sh = {24'b0, pp, 24'b0};
         default: pp_sh = {pp, 48'b0};
      endcase
   end

   // accumulate partial products
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_sh;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

// ===== rtl/core/lj_div.sv =====
// restoring divider for 2^56/den or 2^40/den, one quotient bit per cycle, capped result
// depends on lj_pkg
module lj_div (
   input  logic                clock,
   input  logic                reset,
   input  lj_pkg::div_req_type req,
   output lj_pkg::div_rsp_type rsp
);

   localparam logic [5:0] TOP_BIT   = 6'd56;
   localparam logic [5:0] SMALL_BIT = 6'd40;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      small_ff, small_in;
   logic [5:0]                bit_ff, bit_in;
   logic [63:0]               rem_ff, rem_in, den_ff, den_in;
   logic [lj_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic                      nb;
   logic [64:0]               trial, diff;
   logic                      ge;

   // one restoring step
   assign nb    = small_ff ? (bit_ff == SMALL_BIT) : (bit_ff == TOP_BIT);
   assign trial = {rem_ff, nb};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      small_in = small_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         small_in = req.small_num;
         bit_in   = TOP_BIT;
         rem_in   = '0;
         den_in   = req.den;
         quo_in   = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : trial[63:0];
         quo_in = {quo_ff[55:0], ge};
         bit_in = bit_ff - 6'd1;
         if (bit_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      small_ff <= small_in;
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
   end

   // a zero divisor yields all ones, which caps as well
   assign rsp.done = done_ff;
   assign rsp.quo  = (quo_ff[56:47] != '0) ? lj_pkg::CAP : quo_ff[46:0];

endmodule

// ===== rtl/core/lennard_jones_force_engine_unit.sv =====
// lennard-jones force engine: loads positions, sums pair and wall forces, streams accelerations
// steps: load writes one position per accepted request; compute clears the accumulation memory,
// squares the cutoff, then squares each pair distance and, in range, divides and runs the force
// steps, likewise for each active wall face, on the shared 24x24 multiplier and 57-step divider
// throughput: one particle set at a time; reset is synchronous, restores the register defaults
// and empties the load count; the position memory is not cleared
module lennard_jones_force_engine_unit #(
   parameter int unsigned MAX_PARTICLES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lj_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                   csr_data,
   // request: pos_x, pos_y, pos_z
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lj_pkg::REQ_W-1:0]      req_tdata,
   input  logic                          req_tlast,
   // result: particle_index, acc_x, acc_y, acc_z, total_energy
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lj_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int unsigned IW = $clog2(MAX_PARTICLES);
   localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
   localparam logic [2:0]  FACE_LAST = 3'd5;

   typedef enum logic [19:0] {
      ST_LOAD   = 20'h00001,
      ST_CLR    = 20'h00002,
      ST_RDI    = 20'h00004,
      ST_GETI   = 20'h00008,
      ST_RDJ    = 20'h00010,
      ST_GETJ   = 20'h00020,
      ST_MULGO  = 20'h00040,
      ST_MULW   = 20'h00080,
      ST_DIVGO  = 20'h00100,
      ST_DIVW   = 20'h00200,
      ST_RDA    = 20'h00400,
      ST_WRA    = 20'h00800,
      ST_WALL   = 20'h01000,
      ST_WRI    = 20'h02000,
      ST_ERD    = 20'h04000,
      ST_EGET   = 20'h08000,
      ST_EWALL  = 20'h10000,
      ST_OUTRD  = 20'h20000,
      ST_OUTGET = 20'h40000,
      ST_OUT    = 20'h80000
   } state_type;

   state_type             state_ff, state_in;
   lj_pkg::step_type      step_ff, step_in;
   logic [CW-1:0]         cnt_ff, cnt_in, n_ff, n_in;
   logic [CW-1:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [2:0]            face_ff, face_in;
   logic                  epass_ff, epass_in;
   logic                  divsm_ff, divsm_in;
   logic [31:0]           box_ff, box_in, cut_ff, cut_in;
   logic                  en_ff, en_in;
   logic [63:0]           cut2_ff, cut2_in, r2_ff, r2_in;
   logic [2:0][31:0]      pos_i_ff, pos_i_in;
   logic [2:0][32:0]      d_ff, d_in;
   logic [2:0][47:0]      acc_i_ff, acc_i_in, t_ff, t_in;
   logic [46:0]           u_ff, u_in, u2_ff, u2_in, u3_ff, u3_in, u4_ff, u4_in, u6_ff, u6_in;
   logic [47:0]           mg_ff, mg_in;
   logic                  gneg_ff, gneg_in;
   logic [47:0]           energy_ff, energy_in;
   logic [33:0]           dist_ff, dist_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [lj_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // memories
   logic                  pos_we, acc_we;
   logic [IW-1:0]         pos_waddr, pos_raddr, acc_waddr, acc_raddr;
   logic [95:0]           pos_rdata;
   logic [143:0]          acc_wdata, acc_rdata;

   lj_pkg::mul_req_type   mul_req;
   lj_pkg::mul_rsp_type   mul_rsp;
   lj_pkg::div_req_type   div_req;
   lj_pkg::div_rsp_type   div_rsp;

   // helpers
   logic [CW:0]           i_inc, j_inc, k_inc, cnt_inc;
   logic [1:0]            ax;
   logic [31:0]           wall_c, dist_mag, lim;
   logic [33:0]           dist_now;
   logic                  wall_on;
   logic [46:0]           s24, s16;
   logic [63:0]           r2_next;
   logic [48:0]           gv;
   logic [47:0]           gabs, ediff;
   logic [31:0]           md;
   logic [47:0]           md24;
   logic [1:0]            t_ax;
   logic                  t_sgn;
   logic [47:0]           t_new;
   logic [52:0]           nine_w5, q9_term;
   state_type             nf_state, nj_state;
   logic [2:0]            nf_face;
   logic [CW-1:0]         nf_i, nj_j;
   logic                  out_last;

   lj_ram #(.WIDTH(96), .DEPTH(MAX_PARTICLES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (req_tdata),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   lj_ram #(.WIDTH(144), .DEPTH(MAX_PARTICLES)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_addr (acc_raddr),
      .rd_data (acc_rdata)
   );

   lj_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   lj_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // counters and wall geometry
   assign i_inc   = {1'b0, i_ff} + (CW+1)'(1);
   assign j_inc   = {1'b0, j_ff} + (CW+1)'(1);
   assign k_inc   = {1'b0, k_ff} + (CW+1)'(1);
   assign cnt_inc = {1'b0, cnt_ff} + (CW+1)'(1);
   assign ax       = face_ff[2:1];
   assign wall_c   = pos_i_ff[ax];
   assign lim      = {cut_ff[31:16], 16'b0};
   assign dist_now = face_ff[0] ? ({2'b0, box_ff} - {2'b0, wall_c}) : {2'b0, wall_c};
   assign wall_on  = $signed(dist_now) <= $signed({2'b0, lim});
   assign dist_mag = lj_pkg::abs34(dist_ff);
   assign out_last = (k_inc == {1'b0, n_ff});

   // multiplier results and derived terms
   assign s24     = lj_pkg::sat_shr24(mul_rsp.prod);
   assign s16     = lj_pkg::sat_shr16(mul_rsp.prod);
   assign r2_next = lj_pkg::sat_add64(r2_ff, mul_rsp.prod[63:0]);
   assign gv      = {1'b0, s24, 1'b0} - {2'b0, u4_ff};
   assign gabs    = gv[48] ? 48'(-gv) : gv[47:0];
   assign ediff   = {1'b0, u6_ff} - {1'b0, u3_ff};
   assign nine_w5 = {3'b0, s24, 3'b0} + {6'b0, s24};
   assign q9_term = dist_ff[33] ? -{6'b0, s24} : {6'b0, s24};

   always_comb begin
      case (step_ff)
         lj_pkg::MS_TY: t_ax = 2'd1;
         lj_pkg::MS_TZ: t_ax = 2'd2;
         default:       t_ax = 2'd0;
      endcase
   end

   assign md    = lj_pkg::abs33(d_ff[t_ax]);
   assign md24  = {12'b0, md, 4'b0} + {13'b0, md, 3'b0};
   assign t_sgn = d_ff[t_ax][32] ^ gneg_ff;
   assign t_new = t_sgn ? -{1'b0, s16} : {1'b0, s16};

   // multiplier operand selection
   always_comb begin
      mul_req.start = (state_ff == ST_MULGO);
      mul_req.a     = {1'b0, u_ff};
      mul_req.b     = {1'b0, u_ff};
      case (step_ff)
         lj_pkg::MS_CUT: begin
            mul_req.a = {16'b0, cut_ff};
            mul_req.b = {16'b0, cut_ff};
         end
         lj_pkg::MS_SQX, lj_pkg::MS_SQY, lj_pkg::MS_SQZ: begin
            mul_req.a = {16'b0, lj_pkg::abs33(d_ff[step_ff == lj_pkg::MS_SQX ? 2'd0 :
                                                  step_ff == lj_pkg::MS_SQY ? 2'd1 : 2'd2])};
            mul_req.b = mul_req.a;
         end
         lj_pkg::MS_U3, lj_pkg::MS_W5: begin
            mul_req.a = {1'b0, (step_ff == lj_pkg::MS_U3) ? u2_ff : u4_ff};
         end
         lj_pkg::MS_U4, lj_pkg::MS_W4, lj_pkg::MS_Q4: begin
            mul_req.a = {1'b0, u2_ff};
            mul_req.b = {1'b0, u2_ff};
         end
         lj_pkg::MS_U6: begin
            mul_req.a = {1'b0, u3_ff};
            mul_req.b = {1'b0, u3_ff};
         end
         lj_pkg::MS_U7, lj_pkg::MS_Q9: begin
            mul_req.a = {1'b0, u6_ff};
         end
         lj_pkg::MS_Q8: begin
            mul_req.a = {1'b0, u4_ff};
            mul_req.b = {1'b0, u4_ff};
         end
         lj_pkg::MS_TX, lj_pkg::MS_TY, lj_pkg::MS_TZ: begin
            mul_req.a = md24;
            mul_req.b = mg_ff;
         end
         lj_pkg::MS_WD2: begin
            mul_req.a = {16'b0, dist_mag};
            mul_req.b = {16'b0, dist_mag};
         end
         default: begin
            mul_req.a = {1'b0, u_ff};
            mul_req.b = {1'b0, u_ff};
         end
      endcase
   end

   assign div_req.start     = (state_ff == ST_DIVGO);
   assign div_req.small_num = divsm_ff;
   assign div_req.den       = r2_ff;

   // next wall face, or end of the particle's walls
   always_comb begin
      nf_state = epass_ff ? ST_EWALL : ST_WALL;
      nf_face  = face_ff + 3'd1;
      nf_i     = i_ff;
      if (face_ff == FACE_LAST) begin
         nf_face = 3'd0;
         if (!epass_ff) begin
            nf_state = ST_WRI;
         end else if (i_inc < {1'b0, n_ff}) begin
            nf_state = ST_ERD;
            nf_i     = i_inc[CW-1:0];
         end else begin
            nf_state = ST_OUTRD;
         end
      end
   end

   // next pair partner, or on to the walls
   always_comb begin
      nj_j     = j_inc[CW-1:0];
      nj_state = (j_inc < {1'b0, n_ff}) ? ST_RDJ : ST_WALL;
   end

   // memory ports
   always_comb begin
      pos_we    = (state_ff == ST_LOAD) && req_tvalid && (cnt_ff < CW'(MAX_PARTICLES));
      pos_waddr = cnt_ff[IW-1:0];
      pos_raddr = (state_ff == ST_RDJ) ? j_ff[IW-1:0] : i_ff[IW-1:0];
      acc_we    = 1'b0;
      acc_waddr = i_ff[IW-1:0];
      acc_wdata = acc_i_ff;
      acc_raddr = i_ff[IW-1:0];
      case (state_ff)
         ST_CLR: begin
            acc_we    = 1'b1;
            acc_waddr = k_ff[IW-1:0];
            acc_wdata = '0;
         end
         ST_WRA: begin
            acc_we    = 1'b1;
            acc_waddr = j_ff[IW-1:0];
            for (int a = 0; a < 3; a++) begin
               acc_wdata[48*a +: 48] = lj_pkg::sat_add(acc_rdata[48*a +: 48],
                                                       -lj_pkg::sx53(t_ff[a]));
            end
         end
         ST_WRI: begin
            acc_we = 1'b1;
         end
         ST_RDA:   acc_raddr = j_ff[IW-1:0];
         ST_OUTRD: acc_raddr = k_ff[IW-1:0];
         default: begin
            acc_we = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      face_in      = face_ff;
      epass_in     = epass_ff;
      divsm_in     = divsm_ff;
      box_in       = box_ff;
      cut_in       = cut_ff;
      en_in        = en_ff;
      cut2_in      = cut2_ff;
      r2_in        = r2_ff;
      pos_i_in     = pos_i_ff;
      d_in         = d_ff;
      acc_i_in     = acc_i_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      u2_in        = u2_ff;
      u3_in        = u3_ff;
      u4_in        = u4_ff;
      u6_in        = u6_ff;
      mg_in        = mg_ff;
      gneg_in      = gneg_ff;
      energy_in    = energy_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            lj_pkg::CSR_BOX_SIZE:      box_in = csr_data;
            lj_pkg::CSR_CUTOFF:        cut_in = csr_data;
            lj_pkg::CSR_ENERGY_ENABLE: en_in  = csr_data[0];
            default:                   en_in  = en_ff;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (pos_we) begin
                  cnt_in = cnt_inc[CW-1:0];
               end
               if (req_tlast) begin
                  n_in     = pos_we ? cnt_inc[CW-1:0] : cnt_ff;
                  k_in     = '0;
                  state_in = ST_CLR;
               end
            end
         end
         ST_CLR: begin
            k_in = k_inc[CW-1:0];
            if (k_inc == {1'b0, n_ff}) begin
               step_in  = lj_pkg::MS_CUT;
               state_in = ST_MULGO;
            end
         end
         ST_RDI:  state_in = ST_GETI;
         ST_GETI: begin
            for (int a = 0; a < 3; a++) begin
               pos_i_in[a] = pos_rdata[32*a +: 32];
               acc_i_in[a] = acc_rdata[48*a +: 48];
            end
            j_in     = i_inc[CW-1:0];
            face_in  = 3'd0;
            state_in = (i_inc < {1'b0, n_ff}) ? ST_RDJ : ST_WALL;
         end
         ST_RDJ:  state_in = ST_GETJ;
         ST_GETJ: begin
            for (int a = 0; a < 3; a++) begin
               d_in[a] = {1'b0, pos_i_ff[a]} - {1'b0, pos_rdata[32*a +: 32]};
            end
            step_in  = lj_pkg::MS_SQX;
            state_in = ST_MULGO;
         end
         ST_MULGO: state_in = ST_MULW;
         ST_MULW: begin
            if (mul_rsp.done) begin
               state_in = ST_MULGO;
               case (step_ff)
                  lj_pkg::MS_CUT: begin
                     cut2_in   = mul_rsp.prod[63:0];
                     i_in      = '0;
                     epass_in  = 1'b0;
                     energy_in = '0;
                     state_in  = ST_RDI;
                  end
                  lj_pkg::MS_SQX: begin
                     r2_in   = mul_rsp.prod[63:0];
                     step_in = lj_pkg::MS_SQY;
                  end
                  lj_pkg::MS_SQY: begin
                     r2_in   = r2_next;
                     step_in = lj_pkg::MS_SQZ;
                  end
                  lj_pkg::MS_SQZ: begin
                     r2_in = r2_next;
                     if (r2_next > cut2_ff) begin
                        j_in     = nj_j;
                        face_in  = 3'd0;
                        state_in = nj_state;
                     end else begin
                        divsm_in = 1'b0;
                        state_in = ST_DIVGO;
                     end
                  end
                  lj_pkg::MS_U2: begin
                     u2_in   = s24;
                     step_in = lj_pkg::MS_U3;
                  end
                  lj_pkg::MS_U3: begin
                     u3_in   = s24;
                     step_in = lj_pkg::MS_U4;
                  end
                  lj_pkg::MS_U4: begin
                     u4_in   = s24;
                     step_in = lj_pkg::MS_U6;
                  end
                  lj_pkg::MS_U6: begin
                     u6_in   = s24;
                     step_in = lj_pkg::MS_U7;
                  end
                  lj_pkg::MS_U7: begin
                     mg_in   = gabs;
                     gneg_in = gv[48];
                     step_in = lj_pkg::MS_TX;
                  end
                  lj_pkg::MS_TX: begin
                     t_in[0] = t_new;
                     step_in = lj_pkg::MS_TY;
                  end
                  lj_pkg::MS_TY: begin
                     t_in[1] = t_new;
                     step_in = lj_pkg::MS_TZ;
                  end
                  lj_pkg::MS_TZ: begin
                     t_in[2]  = t_new;
                     state_in = ST_RDA;
                  end
                  lj_pkg::MS_WD2: begin
                     r2_in    = mul_rsp.prod[63:0];
                     divsm_in = 1'b0;
                     state_in = ST_DIVGO;
                  end
                  lj_pkg::MS_W2, lj_pkg::MS_Q2: begin
                     u2_in   = s24;
                     step_in = (step_ff == lj_pkg::MS_W2) ? lj_pkg::MS_W4 : lj_pkg::MS_Q4;
                  end
                  lj_pkg::MS_W4, lj_pkg::MS_Q4: begin
                     u4_in   = s24;
                     step_in = (step_ff == lj_pkg::MS_W4) ? lj_pkg::MS_W5 : lj_pkg::MS_Q8;
                  end
                  lj_pkg::MS_Q8: begin
                     u6_in   = s24;
                     step_in = lj_pkg::MS_Q9;
                  end
                  lj_pkg::MS_W5: begin
                     // low face pushes up, high face pushes down
                     acc_i_in[ax] = lj_pkg::sat_add(acc_i_ff[ax],
                                                    face_ff[0] ? -nine_w5 : nine_w5);
                     face_in  = nf_face;
                     i_in     = nf_i;
                     k_in     = '0;
                     state_in = nf_state;
                  end
                  default: begin
                     // wall energy, negative when the particle is beyond the face
                     energy_in = lj_pkg::sat_add(energy_ff, q9_term);
                     face_in   = nf_face;
                     i_in      = nf_i;
                     k_in      = '0;
                     state_in  = nf_state;
                  end
               endcase
            end
         end
         ST_DIVGO: state_in = ST_DIVW;
         ST_DIVW: begin
            if (div_rsp.done) begin
               u_in     = div_rsp.quo;
               state_in = ST_MULGO;
               case (step_ff)
                  lj_pkg::MS_SQZ: step_in = lj_pkg::MS_U2;
                  lj_pkg::MS_WD2: step_in = lj_pkg::MS_W2;
                  default:        step_in = lj_pkg::MS_Q2;
               endcase
            end
         end
         ST_RDA: state_in = ST_WRA;
         ST_WRA: begin
            for (int a = 0; a < 3; a++) begin
               acc_i_in[a] = lj_pkg::sat_add(acc_i_ff[a], lj_pkg::sx53(t_ff[a]));
            end
            if (en_ff) begin
               energy_in = lj_pkg::sat_add(energy_ff, {{3{ediff[47]}}, ediff, 2'b00});
            end
            j_in     = nj_j;
            face_in  = 3'd0;
            state_in = nj_state;
         end
         ST_WALL: begin
            dist_in = dist_now;
            if (wall_on) begin
               step_in  = lj_pkg::MS_WD2;
               state_in = ST_MULGO;
            end else begin
               face_in  = nf_face;
               state_in = nf_state;
            end
         end
         ST_WRI: begin
            i_in = i_inc[CW-1:0];
            k_in = '0;
            if (i_inc < {1'b0, n_ff}) begin
               state_in = ST_RDI;
            end else if (en_ff) begin
               epass_in = 1'b1;
               i_in     = '0;
               state_in = ST_ERD;
            end else begin
               state_in = ST_OUTRD;
            end
         end
         ST_ERD:  state_in = ST_EGET;
         ST_EGET: begin
            for (int a = 0; a < 3; a++) begin
               pos_i_in[a] = pos_rdata[32*a +: 32];
            end
            face_in  = 3'd0;
            state_in = ST_EWALL;
         end
         ST_EWALL: begin
            dist_in = dist_now;
            if (wall_on) begin
               r2_in    = {32'b0, lj_pkg::abs34(dist_now)};
               divsm_in = 1'b1;
               step_in  = lj_pkg::MS_Q2;
               state_in = ST_DIVGO;
            end else begin
               face_in  = nf_face;
               i_in     = nf_i;
               k_in     = '0;
               state_in = nf_state;
            end
         end
         ST_OUTRD: state_in = ST_OUTGET;
         ST_OUTGET: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = out_last;
            rsp_data_in  = {2'b0, (out_last && en_ff) ? energy_ff : 48'b0,
                            acc_rdata[143:96], acc_rdata[95:48], acc_rdata[47:0],
                            lj_pkg::IDX_W'(k_ff)};
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               k_in         = k_inc[CW-1:0];
               if (rsp_last_ff) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_OUTRD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         step_ff      <= lj_pkg::MS_CUT;
         cnt_ff       <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         face_ff      <= 3'd0;
         epass_ff     <= 1'b0;
         divsm_ff     <= 1'b0;
         box_ff       <= lj_pkg::BOX_RESET;
         cut_ff       <= lj_pkg::CUTOFF_RESET;
         en_ff        <= 1'b1;
         energy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         face_ff      <= face_in;
         epass_ff     <= epass_in;
         divsm_ff     <= divsm_in;
         box_ff       <= box_in;
         cut_ff       <= cut_in;
         en_ff        <= en_in;
         energy_ff    <= energy_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      cut2_ff     <= cut2_in;
      r2_ff       <= r2_in;
      pos_i_ff    <= pos_i_in;
      d_ff        <= d_in;
      acc_i_ff    <= acc_i_in;
      t_ff        <= t_in;
      u_ff        <= u_in;
      u2_ff       <= u2_in;
      u3_ff       <= u3_in;
      u4_ff       <= u4_in;
      u6_ff       <= u6_in;
      mg_ff       <= mg_in;
      gneg_ff     <= gneg_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_load_vs_emit: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("loading while results are pending");
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not ready for a new set after the last result");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_PARTICLES))
      else $error("particle count above capacity");
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start))
      else $error("multiplier and divider started together");
`endif

endmodule
